// ----- rtl/core/assert_macros.svh -----
// ---------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers used by button_click_hold_event_detector
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every rising clk edge outside reset
`define ASSERT_CLKED(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// checked on every rising clk edge, reset included
`define ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- rtl/core/bchd_pkg.sv -----
// ---------------------------------------------------------------------------
// bchd_pkg
// types and constants of the button click / hold event detector
// ---------------------------------------------------------------------------
package bchd_pkg;

	localparam int unsigned TIME_W    = 32;
	localparam int unsigned PERIOD_W  = 16;
	localparam int unsigned COUNT_W   = 8;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DAT_W = 16;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_HOLD_TIME   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_STEP_PERIOD = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MC_WINDOW   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_INVERT      = 3'd3;

	// register reset values
	localparam logic [PERIOD_W-1:0] HOLD_TIME_RST   = 16'd1000;
	localparam logic [PERIOD_W-1:0] STEP_PERIOD_RST = 16'd300;
	localparam logic [PERIOD_W-1:0] MC_WINDOW_RST   = 16'd400;

	localparam logic [COUNT_W-1:0] COUNT_MAX = 8'd255;

	typedef struct packed {
		logic [PERIOD_W-1:0] hold_time_ms;
		logic [PERIOD_W-1:0] step_period_ms;
		logic [PERIOD_W-1:0] multiclick_window_ms;
		logic                invert_level;
	} cfg_t;

	typedef struct packed {
		logic               pressing;
		logic               holding;
		logic [TIME_W-1:0]  press_start;
		logic [TIME_W-1:0]  last_step;
		logic [COUNT_W-1:0] clicks;
	} state_t;

	typedef struct packed {
		logic              raw_pressed;
		logic [TIME_W-1:0] now_ms;
	} sample_t;

	typedef struct packed {
		logic               press_event;
		logic               hold_event;
		logic               step_event;
		logic               short_release_event;
		logic               hold_release_event;
		logic               is_pressing;
		logic               is_holding;
		logic               multiclick_valid;
		logic [COUNT_W-1:0] multiclick_count;
		logic [TIME_W-1:0]  held_time_ms;
		logic               busy_res;
	} result_t;

endpackage

// ----- rtl/core/bchd_sample_if.sv -----
// ---------------------------------------------------------------------------
// bchd_sample_if
// valid/ready channel carrying one button sample per beat
// ---------------------------------------------------------------------------
interface bchd_sample_if;
	import bchd_pkg::*;

	logic              valid;
	logic              ready;
	logic              raw_pressed;
	logic [TIME_W-1:0] now_ms;

	modport source (output valid, output raw_pressed, output now_ms, input ready);
	modport sink   (input valid, input raw_pressed, input now_ms, output ready);
endinterface

// ----- rtl/core/bchd_result_if.sv -----
// ---------------------------------------------------------------------------
// bchd_result_if
// valid/ready channel carrying one event result per beat
// ---------------------------------------------------------------------------
interface bchd_result_if;
	import bchd_pkg::*;

	logic               valid;
	logic               ready;
	logic               press_event;
	logic               hold_event;
	logic               step_event;
	logic               short_release_event;
	logic               hold_release_event;
	logic               is_pressing;
	logic               is_holding;
	logic               multiclick_valid;
	logic [COUNT_W-1:0] multiclick_count;
	logic [TIME_W-1:0]  held_time_ms;
	logic               busy_res;

	modport source (
		output valid, input ready,
		output press_event, output hold_event, output step_event,
		output short_release_event, output hold_release_event,
		output is_pressing, output is_holding,
		output multiclick_valid, output multiclick_count,
		output held_time_ms, output busy_res
	);
	modport sink (
		input valid, output ready,
		input press_event, input hold_event, input step_event,
		input short_release_event, input hold_release_event,
		input is_pressing, input is_holding,
		input multiclick_valid, input multiclick_count,
		input held_time_ms, input busy_res
	);
endinterface

// ----- rtl/core/bchd_cfg_regs.sv -----
// ---------------------------------------------------------------------------
// bchd_cfg_regs
// configuration register file, write only
// ---------------------------------------------------------------------------
module bchd_cfg_regs (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [bchd_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  logic [bchd_pkg::CFG_DAT_W-1:0]   cfg_wdata,
	output bchd_pkg::cfg_t                   cfg
);
	import bchd_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.hold_time_ms         <= HOLD_TIME_RST;
			cfg_q.step_period_ms       <= STEP_PERIOD_RST;
			cfg_q.multiclick_window_ms <= MC_WINDOW_RST;
			cfg_q.invert_level         <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_HOLD_TIME:   cfg_q.hold_time_ms         <= cfg_wdata;
				CFG_STEP_PERIOD: cfg_q.step_period_ms       <= cfg_wdata;
				CFG_MC_WINDOW:   cfg_q.multiclick_window_ms <= cfg_wdata;
				CFG_INVERT:      cfg_q.invert_level         <= cfg_wdata[0];
				default: ; // unused indexes are dropped
			endcase
		end
	end

	assign cfg = cfg_q;
endmodule

// ----- rtl/core/bchd_eval.sv -----
// ---------------------------------------------------------------------------
// bchd_eval
// next state and event flags for one sample
// ---------------------------------------------------------------------------
module bchd_eval (
	input  bchd_pkg::cfg_t    cfg,
	input  bchd_pkg::state_t  state,
	input  bchd_pkg::sample_t smp,
	output bchd_pkg::state_t  state_nxt,
	output bchd_pkg::result_t res
);
	import bchd_pkg::*;

	logic              lvl;
	logic [TIME_W-1:0] since_press;
	logic [TIME_W-1:0] since_step;
	logic              win_closed;
	logic              step_due;
	logic              hold_due;
	logic [COUNT_W-1:0] clicks_win;

	assign lvl         = smp.raw_pressed ^ cfg.invert_level;
	assign since_press = smp.now_ms - state.press_start;
	assign since_step  = smp.now_ms - state.last_step;
	assign win_closed  = since_press >= TIME_W'(cfg.multiclick_window_ms);
	assign step_due    = since_step >= TIME_W'(cfg.step_period_ms);
	assign hold_due    = since_press >= TIME_W'(cfg.hold_time_ms);
	assign clicks_win  = win_closed ? '0 : state.clicks;

	always_comb begin
		state_nxt        = state;
		state_nxt.clicks = clicks_win;
		res              = '0;

		// window check uses the press start held before this sample
		res.multiclick_valid = win_closed && (state.clicks > COUNT_W'(1));
		res.multiclick_count = res.multiclick_valid ? state.clicks : '0;

		priority if (lvl && !state.pressing) begin
			if (clicks_win != COUNT_MAX) begin
				state_nxt.clicks = clicks_win + COUNT_W'(1);
			end
			state_nxt.pressing    = 1'b1;
			state_nxt.press_start = smp.now_ms;
			res.press_event       = 1'b1;
		end else if (lvl && state.holding) begin
			if (step_due) begin
				// advance by one period so late samples catch up
				state_nxt.last_step = state.last_step + TIME_W'(cfg.step_period_ms);
				res.step_event      = 1'b1;
			end
		end else if (lvl) begin
			if (hold_due) begin
				state_nxt.last_step = smp.now_ms;
				state_nxt.holding   = 1'b1;
				res.hold_event      = 1'b1;
			end
		end else if (state.pressing) begin
			if (state.holding) begin
				res.hold_release_event = 1'b1;
				res.held_time_ms       = since_press;
			end else begin
				res.short_release_event = 1'b1;
			end
			state_nxt.pressing = 1'b0;
			state_nxt.holding  = 1'b0;
		end else begin
			// released and idle: nothing beyond the window check
		end

		res.is_pressing = state_nxt.pressing;
		res.is_holding  = state_nxt.holding;
		res.busy_res    = state_nxt.pressing || (state_nxt.clicks != '0);
	end
endmodule

// ----- rtl/core/button_click_hold_event_detector.sv -----
// ---------------------------------------------------------------------------
// button_click_hold_event_detector
// press, hold, step, release and multiclick events from timestamped samples
//
// sample channel: one beat per button sample (raw level, 32-bit ms stamp).
// report channel: exactly one beat per sample, in order, with the one-shot
// event flags, the pressing / holding / busy levels, a multiclick count and
// the held time on a hold release.
// path: a sample goes through the input register, then the result register.
// throughput: one sample per cycle when not stalled; the input register
// feeds the event logic, which updates the state registers and the result
// register at the same edge, so the next sample sees the updated state at once.
// stall: while report.ready is low the result register holds its beat and
// one more sample may wait in the input register; sample.ready then drops.
// reset: arst_n clears the state and both valid flags, and loads the
// configuration defaults (hold 1000 ms, step 300 ms, window 400 ms, no
// inversion). configuration is written through cfg_we / cfg_idx / cfg_wdata;
// the user must write it only while no sample is in flight (not enforced).
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module button_click_hold_event_detector (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [bchd_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [bchd_pkg::CFG_DAT_W-1:0] cfg_wdata,
	bchd_sample_if.sink                    sample,
	bchd_result_if.source                  report
);
	import bchd_pkg::*;

	cfg_t    cfg;
	state_t  state_q;
	state_t  state_nxt;
	sample_t smp_in;
	sample_t smp_s1;
	logic    valid_s1;
	result_t res_nxt;
	result_t res_s2;
	logic    valid_s2;
	logic    advance;

	// configuration registers
	bchd_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	// the held sample moves on when the result register is free or drains now
	assign advance      = valid_s1 && (!valid_s2 || report.ready);
	assign sample.ready = !valid_s1 || advance;

	assign smp_in.raw_pressed = sample.raw_pressed;
	assign smp_in.now_ms      = sample.now_ms;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample.valid && sample.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (sample.valid && sample.ready) begin
			smp_s1 <= smp_in;
		end
	end

	// event logic between the input register and the result register
	bchd_eval u_eval (
		.cfg       (cfg),
		.state     (state_q),
		.smp       (smp_s1),
		.state_nxt (state_nxt),
		.res       (res_nxt)
	);

	// button state, committed together with the result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (report.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_nxt;
		end
	end

	assign report.valid               = valid_s2;
	assign report.press_event         = res_s2.press_event;
	assign report.hold_event          = res_s2.hold_event;
	assign report.step_event          = res_s2.step_event;
	assign report.short_release_event = res_s2.short_release_event;
	assign report.hold_release_event  = res_s2.hold_release_event;
	assign report.is_pressing         = res_s2.is_pressing;
	assign report.is_holding          = res_s2.is_holding;
	assign report.multiclick_valid    = res_s2.multiclick_valid;
	assign report.multiclick_count    = res_s2.multiclick_count;
	assign report.held_time_ms        = res_s2.held_time_ms;
	assign report.busy_res            = res_s2.busy_res;

	// at most one one-shot event per beat
	`ASSERT_CLKED(a_one_event, valid_s2 |-> $onehot0({res_s2.press_event, res_s2.hold_event, res_s2.step_event, res_s2.short_release_event, res_s2.hold_release_event}), "more than one event in a beat")
	// holding never outlives pressing
	`ASSERT_ALWAYS(a_hold_in_press, state_q.holding |-> state_q.pressing, "holding without pressing")
	// a release leaves the button idle
	`ASSERT_CLKED(a_release_idle, (valid_s2 && (res_s2.hold_release_event || res_s2.short_release_event)) |-> (!res_s2.is_pressing && !res_s2.is_holding), "pressing after release")
	// a reported sequence has at least two clicks
	`ASSERT_CLKED(a_mc_count, (valid_s2 && res_s2.multiclick_valid) |-> (res_s2.multiclick_count > 8'd1), "multiclick count too small")
	// an advancing sample always fills the result register
	`ASSERT_CLKED(a_adv_fills, advance |=> valid_s2, "result register not loaded")
endmodule
